@@ design/ccpt_pkg.sv @@
// Shared constants, tables and small modular helpers for the cubic curve point test.
package ccpt_pkg;

  localparam int N_W     = 25;
  localparam int X_W     = 31;
  localparam int F_W     = 128;
  localparam int ROOT_W  = 64;
  localparam int IN_TW   = 56;
  localparam int OUT_TW  = 72;

  localparam int POLY_STG = 8;
  localparam int SQRT_STG = ROOT_W;
  localparam int NSTG     = POLY_STG + SQRT_STG + 1;

  localparam int PRIME_COUNT  = 10;
  localparam int SIEVE_PRIMES = 10;
  localparam int SIEVE_USED   = (SIEVE_PRIMES > PRIME_COUNT) ? PRIME_COUNT : SIEVE_PRIMES;
  localparam int RED_SH       = 20;

  localparam logic [4:0] PRIME [PRIME_COUNT] = '{5'd3, 5'd5, 5'd7, 5'd11, 5'd13,
                                                 5'd17, 5'd19, 5'd23, 5'd29, 5'd31};
  // ceil-ish reciprocal: floor(2^20 / p) + 1
  localparam logic [18:0] RECIP [PRIME_COUNT] = '{19'd349526, 19'd209716, 19'd149797,
                                                  19'd95326, 19'd80660, 19'd61681,
                                                  19'd55189, 19'd45591, 19'd36158,
                                                  19'd33826};
  // 256^k mod p
  localparam logic [4:0] W1 [PRIME_COUNT] = '{5'd1, 5'd1, 5'd4, 5'd3, 5'd9,
                                              5'd1, 5'd9, 5'd3, 5'd24, 5'd8};
  localparam logic [4:0] W2 [PRIME_COUNT] = '{5'd1, 5'd1, 5'd2, 5'd9, 5'd3,
                                              5'd1, 5'd5, 5'd9, 5'd25, 5'd2};
  localparam logic [4:0] W3 [PRIME_COUNT] = '{5'd1, 5'd1, 5'd1, 5'd5, 5'd1,
                                              5'd1, 5'd7, 5'd4, 5'd20, 5'd16};
  // 2^30 mod p (x offset); n offset 2^24 mod p equals W3
  localparam logic [4:0] OFFX [PRIME_COUNT] = '{5'd1, 5'd4, 5'd1, 5'd1, 5'd12,
                                                5'd13, 5'd11, 5'd3, 5'd4, 5'd1};

  // v mod p for v < 2^15, by reciprocal multiply and one correction
  function automatic logic [4:0] red(input logic [14:0] v, input int i);
    logic [33:0] prod;
    logic [14:0] q;
    logic [19:0] qp;
    logic signed [20:0] r;
    prod = 34'(v) * 34'(RECIP[i]);
    q    = prod[33:RED_SH] > 14'h3fff ? 15'h7fff : 15'(prod[33:RED_SH]);
    qp   = 20'(q) * 20'(PRIME[i]);
    r    = $signed(21'(v)) - $signed(21'(qp));
    if (r < 0) r = r + $signed(21'(PRIME[i]));
    return r[4:0];
  endfunction

  function automatic logic is_qr(input logic [4:0] r, input int i);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 31; k++) begin
      if (k < int'(PRIME[i]) && red(15'(k * k), i) == r) hit = 1'b1;
    end
    return hit;
  endfunction

  typedef struct packed {
    logic neg;
    logic pass;
  } side_t;

endpackage

@@ design/ccpt_sieve.sv @@
// Quadratic residue pre-filter over the small primes, eight pipeline stages.
module ccpt_sieve (
  input  logic                          clk,
  input  logic [ccpt_pkg::POLY_STG-1:0] en,
  input  logic signed [ccpt_pkg::N_W-1:0] n_index,
  input  logic signed [ccpt_pkg::X_W-1:0] x_coord,
  output logic                          sieve_pass
);

  logic [ccpt_pkg::PRIME_COUNT-1:0] qr_ok;
  logic [ccpt_pkg::PRIME_COUNT-1:0] use_mask;
  logic                             pass_r;
  logic [ccpt_pkg::X_W-1:0]         xu;
  logic [ccpt_pkg::N_W-1:0]         nu;

  assign xu = {~x_coord[ccpt_pkg::X_W-1], x_coord[ccpt_pkg::X_W-2:0]};
  assign nu = {~n_index[ccpt_pkg::N_W-1], n_index[ccpt_pkg::N_W-2:0]};

  for (genvar i = 0; i < ccpt_pkg::PRIME_COUNT; i++) begin : g_p
    logic [4:0] xm_r, nm_r;
    logic [4:0] s1_t_r, s1_x2_r, s1_n2_r, s1_x_r, s1_n_r;
    logic [4:0] s2_t_r, s2_t2_r, s2_x3_r, s2_n3_r, s2_x_r, s2_n_r, s2_x2_r, s2_n2_r;
    logic [4:0] s3_a_r, s3_b_r, s3_cp_r, s3_t_r, s3_x_r, s3_x2_r, s3_x3_r;
    logic [4:0] s4_ax2_r, s4_bt_r, s4_ct_r, s4_x_r, s4_x3_r;
    logic [4:0] s5_btx_r, s5_ax2_r, s5_ct_r, s5_x3_r;
    logic [4:0] s6_f_r;
    logic [14:0] xsum_nxt, nsum_nxt, cp_nxt, f_nxt;

    assign use_mask[i] = (i < ccpt_pkg::SIEVE_USED);

    always_comb begin
      xsum_nxt = 15'(xu[7:0]) + 15'(xu[15:8]) * 15'(ccpt_pkg::W1[i])
               + 15'(xu[23:16]) * 15'(ccpt_pkg::W2[i])
               + 15'(xu[30:24]) * 15'(ccpt_pkg::W3[i])
               + 15'(ccpt_pkg::PRIME[i]) - 15'(ccpt_pkg::OFFX[i]);
      nsum_nxt = 15'(nu[7:0]) + 15'(nu[15:8]) * 15'(ccpt_pkg::W1[i])
               + 15'(nu[23:16]) * 15'(ccpt_pkg::W2[i])
               + 15'(nu[24]) * 15'(ccpt_pkg::W3[i])
               + 15'(ccpt_pkg::PRIME[i]) - 15'(ccpt_pkg::W3[i]);
      cp_nxt = 15'(ccpt_pkg::red(15'd11664, i)) * 15'(s2_n3_r)
             + 15'(ccpt_pkg::red(15'd26244, i)) * 15'(s2_n2_r)
             + 15'(ccpt_pkg::red(15'd19683, i)) * 15'(s2_n_r)
             + 15'(ccpt_pkg::red(15'd4916, i));
      f_nxt = 15'(s5_x3_r) + 15'(s5_ax2_r) + 15'(s5_btx_r) + 15'(s5_ct_r);
      qr_ok[i] = ccpt_pkg::is_qr(s6_f_r, i);
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        xm_r <= ccpt_pkg::red(xsum_nxt, i);
        nm_r <= ccpt_pkg::red(nsum_nxt, i);
      end
      if (en[1]) begin
        s1_t_r  <= ccpt_pkg::red(15'(nm_r) * 15'd4 + 15'd3, i);
        s1_x2_r <= ccpt_pkg::red(15'(xm_r) * 15'(xm_r), i);
        s1_n2_r <= ccpt_pkg::red(15'(nm_r) * 15'(nm_r), i);
        s1_x_r  <= xm_r;
        s1_n_r  <= nm_r;
      end
      if (en[2]) begin
        s2_t2_r <= ccpt_pkg::red(15'(s1_t_r) * 15'(s1_t_r), i);
        s2_x3_r <= ccpt_pkg::red(15'(s1_x2_r) * 15'(s1_x_r), i);
        s2_n3_r <= ccpt_pkg::red(15'(s1_n2_r) * 15'(s1_n_r), i);
        s2_t_r  <= s1_t_r;
        s2_x_r  <= s1_x_r;
        s2_n_r  <= s1_n_r;
        s2_x2_r <= s1_x2_r;
        s2_n2_r <= s1_n2_r;
      end
      if (en[3]) begin
        s3_a_r  <= ccpt_pkg::red(15'(ccpt_pkg::red(15'd81, i)) * 15'(s2_t2_r), i);
        s3_b_r  <= ccpt_pkg::red(15'(ccpt_pkg::red(15'd243, i)) * 15'(s2_t2_r), i);
        s3_cp_r <= ccpt_pkg::red(cp_nxt, i);
        s3_t_r  <= s2_t_r;
        s3_x_r  <= s2_x_r;
        s3_x2_r <= s2_x2_r;
        s3_x3_r <= s2_x3_r;
      end
      if (en[4]) begin
        s4_ax2_r <= ccpt_pkg::red(15'(s3_a_r) * 15'(s3_x2_r), i);
        s4_bt_r  <= ccpt_pkg::red(15'(s3_b_r) * 15'(s3_t_r), i);
        s4_ct_r  <= ccpt_pkg::red(15'(s3_t_r) * 15'(s3_cp_r), i);
        s4_x_r   <= s3_x_r;
        s4_x3_r  <= s3_x3_r;
      end
      if (en[5]) begin
        s5_btx_r <= ccpt_pkg::red(15'(s4_bt_r) * 15'(s4_x_r), i);
        s5_ax2_r <= s4_ax2_r;
        s5_ct_r  <= s4_ct_r;
        s5_x3_r  <= s4_x3_r;
      end
      if (en[6]) begin
        s6_f_r <= ccpt_pkg::red(f_nxt, i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) pass_r <= &(qr_ok | ~use_mask);
  end

  assign sieve_pass = pass_r;

endmodule

@@ design/ccpt_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, plus exact-square check.
module ccpt_isqrt (
  input  logic                          clk,
  input  logic [ccpt_pkg::SQRT_STG:0]   en,
  input  logic [ccpt_pkg::F_W-1:0]      rad,
  input  ccpt_pkg::side_t               side_in,
  output logic                          on_curve,
  output logic [ccpt_pkg::ROOT_W-1:0]   root_y,
  output ccpt_pkg::side_t               side_out
);

  logic [ccpt_pkg::F_W-1:0]    rem_r  [ccpt_pkg::SQRT_STG];
  logic [ccpt_pkg::ROOT_W-1:0] root_r [ccpt_pkg::SQRT_STG];
  ccpt_pkg::side_t             side_r [ccpt_pkg::SQRT_STG];
  logic                        on_r;
  logic [ccpt_pkg::ROOT_W-1:0] y_r;
  ccpt_pkg::side_t             so_r;

  for (genvar k = 0; k < ccpt_pkg::SQRT_STG; k++) begin : g_s
    localparam int B = ccpt_pkg::ROOT_W - 1 - k;
    logic [ccpt_pkg::F_W-1:0]    rem_in, trial;
    logic [ccpt_pkg::ROOT_W-1:0] root_in;
    ccpt_pkg::side_t             side_nxt;

    if (k == 0) begin : g_first
      assign rem_in   = rad;
      assign root_in  = '0;
      assign side_nxt = side_in;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign root_in  = root_r[k-1];
      assign side_nxt = side_r[k-1];
    end

    assign trial = (ccpt_pkg::F_W'(root_in) << (B + 1)) | (ccpt_pkg::F_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side_r[k] <= side_nxt;
        if (rem_in >= trial) begin
          rem_r[k]  <= rem_in - trial;
          root_r[k] <= root_in | (ccpt_pkg::ROOT_W'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ccpt_pkg::SQRT_STG]) begin
      so_r <= side_r[ccpt_pkg::SQRT_STG-1];
      on_r <= !side_r[ccpt_pkg::SQRT_STG-1].neg && (rem_r[ccpt_pkg::SQRT_STG-1] == '0);
      y_r  <= (!side_r[ccpt_pkg::SQRT_STG-1].neg && (rem_r[ccpt_pkg::SQRT_STG-1] == '0))
              ? root_r[ccpt_pkg::SQRT_STG-1] : '0;
    end
  end

  assign on_curve = on_r;
  assign root_y   = y_r;
  assign side_out = so_r;

endmodule

@@ design/cubic_curve_point_test_unit.sv @@
// Top level: exact 128-bit curve polynomial, square root and residue sieve pipeline.
//
//  channel | dir | fields (lsb first)
//  in_     | in  | n_index[24:0], x_coord[55:25]
//  out_    | out | on_curve[0], root_y[64:1], sieve_pass[65], value_negative[66]
//
// One transaction per cycle while the output is not stalled. Stages: 8 polynomial,
// 64 root-bit, one output register. The root-bit stages, one 128-bit compare/subtract
// each, set the depth. Synchronous reset clears the valid bits only.
// A stalled output holds; upstream stages keep filling empty slots.
module cubic_curve_point_test_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ccpt_pkg::IN_TW-1:0]    in_tdata,   // n_index, x_coord
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ccpt_pkg::OUT_TW-1:0]   out_tdata   // on_curve, root_y, sieve_pass,
                                                    // value_negative, zero pad
);

  logic [ccpt_pkg::NSTG-1:0] v_r;
  logic [ccpt_pkg::NSTG:0]   rdy;

  logic signed [ccpt_pkg::N_W-1:0] n_in;
  logic signed [ccpt_pkg::X_W-1:0] x_in;

  logic signed [24:0]  p0_n_r, p1_n_r;
  logic signed [30:0]  p0_x_r, p1_x_r, p2_x_r, p3_x_r, p4_x_r, p5_x_r;
  logic signed [26:0]  p0_t_r, p1_t_r, p2_t_r, p3_t_r, p4_t_r;
  logic signed [53:0]  p1_t2_r;
  logic signed [49:0]  p1_n2_r;
  logic signed [54:0]  p2_t3l_r;
  logic signed [53:0]  p2_t3h_r;
  logic signed [50:0]  p2_n3l_r;
  logic signed [49:0]  p2_n3h_r;
  logic signed [63:0]  p2_f1a_r;
  logic signed [65:0]  p2_cpl_r, p3_cpl_r;
  logic signed [80:0]  p3_t3_r;
  logic signed [74:0]  p3_n3_r;
  logic signed [63:0]  p3_f1l_r;
  logic signed [62:0]  p3_f1h_r;
  logic signed [88:0]  p4_b_r;
  logic signed [87:0]  p4_cp_r;
  logic signed [94:0]  p4_f1_r;
  logic signed [95:0]  p5_f2a_r;
  logic signed [57:0]  p5_c0_r, p5_c1_r;
  logic signed [54:0]  p5_c2_r;
  logic signed [115:0] p6_c_r;
  logic signed [63:0]  p6_g0_r, p6_g1_r;
  logic signed [62:0]  p6_g2_r;
  logic signed [127:0] p7_f_r;

  logic                          sv_pass;
  logic                          sq_on;
  logic [ccpt_pkg::ROOT_W-1:0]   sq_root;
  ccpt_pkg::side_t               sq_side_in, sq_side_out;

  assign n_in = in_tdata[24:0];
  assign x_in = in_tdata[55:25];

  always_comb begin
    rdy[ccpt_pkg::NSTG] = out_tready;
    for (int i = ccpt_pkg::NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < ccpt_pkg::NSTG; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // wide products are split into limbs of 25 to 32 bits and summed a stage later
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p0_n_r <= n_in;
      p0_x_r <= x_in;
      p0_t_r <= 27'(n_in) * 27'sd4 + 27'sd3;
    end
    if (rdy[1]) begin
      p1_t2_r <= 54'(p0_t_r) * 54'(p0_t_r);
      p1_n2_r <= 50'(p0_n_r) * 50'(p0_n_r);
      p1_n_r  <= p0_n_r;
      p1_t_r  <= p0_t_r;
      p1_x_r  <= p0_x_r;
    end
    if (rdy[2]) begin
      p2_t3l_r <= 55'($signed({1'b0, p1_t2_r[26:0]})) * 55'(p1_t_r);
      p2_t3h_r <= 54'($signed(p1_t2_r[53:27])) * 54'(p1_t_r);
      p2_n3l_r <= 51'($signed({1'b0, p1_n2_r[24:0]})) * 51'(p1_n_r);
      p2_n3h_r <= 50'($signed(p1_n2_r[49:25])) * 50'(p1_n_r);
      p2_f1a_r <= 64'(p1_x_r) + 64'(p1_t2_r) * 64'sd81;
      p2_cpl_r <= 66'(p1_n2_r) * 66'sd26244 + 66'(p1_n_r) * 66'sd19683 + 66'sd4916;
      p2_t_r   <= p1_t_r;
      p2_x_r   <= p1_x_r;
    end
    if (rdy[3]) begin
      p3_t3_r  <= (81'(p2_t3h_r) <<< 27) + 81'(p2_t3l_r);
      p3_n3_r  <= (75'(p2_n3h_r) <<< 25) + 75'(p2_n3l_r);
      p3_f1l_r <= 64'($signed({1'b0, p2_f1a_r[31:0]})) * 64'(p2_x_r);
      p3_f1h_r <= 63'($signed(p2_f1a_r[63:32])) * 63'(p2_x_r);
      p3_cpl_r <= p2_cpl_r;
      p3_t_r   <= p2_t_r;
      p3_x_r   <= p2_x_r;
    end
    if (rdy[4]) begin
      p4_b_r  <= 89'(p3_t3_r) * 89'sd243;
      p4_cp_r <= 88'(p3_n3_r) * 88'sd11664 + 88'(p3_cpl_r);
      p4_f1_r <= (95'(p3_f1h_r) <<< 32) + 95'(p3_f1l_r);
      p4_t_r  <= p3_t_r;
      p4_x_r  <= p3_x_r;
    end
    if (rdy[5]) begin
      p5_f2a_r <= 96'(p4_f1_r) + 96'(p4_b_r);
      p5_c0_r  <= 58'($signed({1'b0, p4_cp_r[29:0]})) * 58'(p4_t_r);
      p5_c1_r  <= 58'($signed({1'b0, p4_cp_r[59:30]})) * 58'(p4_t_r);
      p5_c2_r  <= 55'($signed(p4_cp_r[87:60])) * 55'(p4_t_r);
      p5_x_r   <= p4_x_r;
    end
    if (rdy[6]) begin
      p6_c_r  <= (116'(p5_c2_r) <<< 60) + (116'(p5_c1_r) <<< 30) + 116'(p5_c0_r);
      p6_g0_r <= 64'($signed({1'b0, p5_f2a_r[31:0]})) * 64'(p5_x_r);
      p6_g1_r <= 64'($signed({1'b0, p5_f2a_r[63:32]})) * 64'(p5_x_r);
      p6_g2_r <= 63'($signed(p5_f2a_r[95:64])) * 63'(p5_x_r);
    end
    if (rdy[7]) begin
      p7_f_r <= (128'(p6_g2_r) <<< 64) + (128'(p6_g1_r) <<< 32) + 128'(p6_g0_r)
              + 128'(p6_c_r);
    end
  end

  ccpt_sieve u_sieve (
    .clk        (clk),
    .en         (rdy[ccpt_pkg::POLY_STG-1:0]),
    .n_index    (n_in),
    .x_coord    (x_in),
    .sieve_pass (sv_pass)
  );

  assign sq_side_in.neg  = p7_f_r[127];
  assign sq_side_in.pass = sv_pass;

  ccpt_isqrt u_isqrt (
    .clk      (clk),
    .en       (rdy[ccpt_pkg::NSTG-1:ccpt_pkg::POLY_STG]),
    .rad      (p7_f_r[127] ? '0 : p7_f_r),
    .side_in  (sq_side_in),
    .on_curve (sq_on),
    .root_y   (sq_root),
    .side_out (sq_side_out)
  );

  assign out_tvalid = v_r[ccpt_pkg::NSTG-1];
  assign out_tdata  = {5'b0, sq_side_out.neg, sq_side_out.pass, sq_root, sq_on};

endmodule

@@ design/ccpt_chk.sv @@
// Port-level checker for the cubic curve point test unit, bound to the top level.
module ccpt_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [ccpt_pkg::OUT_TW-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid result after reset");

  a_neg_square: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[66]))
    else $error("negative value reported as square");

  a_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[64:1] == '0)
    else $error("root nonzero for non-square");

endmodule

bind cubic_curve_point_test_unit ccpt_chk u_ccpt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
